/* hw/rtl/smcu_pkg.sv */
package smcu_pkg;

  localparam int TAP_REGS  = 7;
  localparam int TAP_BITS  = 16;
  localparam int COEF_FRAC = 15;
  localparam int HW_BITS   = 2;
  localparam int REG_IDX_BITS = 3;

  // register index of the half-width register; taps lie at 0..TAP_REGS-1
  localparam logic [REG_IDX_BITS-1:0] REG_HALF_WIDTH = 3'd7;
  localparam logic [HW_BITS-1:0]      HALF_WIDTH_RST = 2'd1;

  // what the front decided about one shift
  typedef struct packed {
    logic emit;   // shift produces a result
    logic last;   // result closes the vector
    logic clear;  // clear the delay line after this shift
  } op_ctl_t;

endpackage

/* hw/rtl/smcu_front.sv */
module smcu_front
  import smcu_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          is_last,
  input  logic [HW_BITS-1:0]            half_width,
  input  logic                          q_full,
  output logic                          push,
  output logic signed [SAMPLE_BITS-1:0] push_x,
  output op_ctl_t                       push_ctl
);

  logic [HW_BITS-1:0] seen;
  logic [HW_BITS-1:0] flush_left;
  logic               flushing;
  logic               final_shift;

  assign in_ready = !flushing && !q_full;
  assign push     = flushing ? !q_full : (in_valid && !q_full);
  assign push_x   = flushing ? '0 : sample;

  always_comb begin
    if (flushing) begin
      final_shift = (flush_left == HW_BITS'(1));
    end else begin
      final_shift = is_last && (half_width == '0);
    end
    push_ctl.emit  = (seen >= half_width);
    push_ctl.last  = (seen >= half_width) && final_shift;
    push_ctl.clear = final_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= '0;
      flush_left <= '0;
      flushing   <= 1'b0;
    end else if (push) begin
      if (final_shift) begin
        seen     <= '0;
        flushing <= 1'b0;
      end else begin
        if (seen < half_width) begin
          seen <= seen + HW_BITS'(1);
        end
        if (!flushing && is_last) begin
          flushing   <= 1'b1;
          flush_left <= half_width;
        end else if (flushing) begin
          flush_left <= flush_left - HW_BITS'(1);
        end
      end
    end
  end

endmodule

/* hw/rtl/smcu_queue.sv */
module smcu_queue
  import smcu_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int DEPTH       = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic signed [SAMPLE_BITS-1:0] push_x,
  input  op_ctl_t                       push_ctl,
  output logic                          full,
  input  logic                          pop,
  output logic                          pop_valid,
  output logic signed [SAMPLE_BITS-1:0] pop_x,
  output op_ctl_t                       pop_ctl
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic signed [SAMPLE_BITS-1:0] x_q [DEPTH];
  op_ctl_t                       ctl_q [DEPTH];
  logic [PTR_W-1:0]              wr_ptr;
  logic [PTR_W-1:0]              rd_ptr;
  logic [CNT_W-1:0]              count;
  logic                          do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_x     = x_q[rd_ptr];
  assign pop_ctl   = ctl_q[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      x_q[wr_ptr]   <= push_x;
      ctl_q[wr_ptr] <= push_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/smcu_back.sv */
module smcu_back
  import smcu_pkg::*;
#(
  parameter int MAX_TAPS    = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  logic signed [SAMPLE_BITS-1:0] q_x,
  input  op_ctl_t                       q_ctl,
  output logic                          pop,
  input  logic signed [TAP_BITS-1:0]    taps [TAP_REGS],
  input  logic [HW_BITS-1:0]            half_width,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] result,
  output logic                          result_last
);

  localparam int NT     = (MAX_TAPS < TAP_REGS) ? MAX_TAPS : TAP_REGS;
  localparam int PROD_W = TAP_BITS + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + $clog2(NT);
  localparam int RND_W  = ACC_W + 1;
  localparam int Q_W    = RND_W - COEF_FRAC;

  logic                          adv;
  logic signed [SAMPLE_BITS-1:0] dl [NT];
  logic                          clr_pend;
  logic                          s0_valid;
  logic                          s0_last;
  logic signed [PROD_W-1:0]      prod [NT];
  logic                          s1_valid;
  logic                          s1_last;
  logic signed [ACC_W-1:0]       acc;
  logic                          s2_valid;
  logic                          s2_last;
  logic signed [TAP_BITS-1:0]    tap_eff [NT];
  logic signed [ACC_W-1:0]       sum;
  logic signed [RND_W-1:0]       rnd;
  logic signed [Q_W-1:0]         q;
  logic signed [SAMPLE_BITS-1:0] sat;

  localparam logic signed [Q_W-1:0] Q_HI = Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [Q_W-1:0] Q_LO = Q_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  // whole pipeline advances while the output register can take a value
  assign adv = !out_valid || out_ready;
  assign pop = adv && q_valid;

  always_comb begin
    for (int j = 0; j < NT; j++) begin
      tap_eff[j] = (j <= 2 * int'(half_width)) ? taps[j] : '0;
    end
    sum = '0;
    for (int j = 0; j < NT; j++) begin
      sum = sum + ACC_W'(prod[j]);
    end
    rnd = RND_W'(acc) + RND_W'(1 << (COEF_FRAC - 1));
    q   = Q_W'(rnd >>> COEF_FRAC);
    if (q > Q_HI) begin
      sat = SAMPLE_BITS'(Q_HI);
    end else if (q < Q_LO) begin
      sat = SAMPLE_BITS'(Q_LO);
    end else begin
      sat = SAMPLE_BITS'(q);
    end
  end

  // shift; after a vector's final shift the next one starts from a clear line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NT; j++) begin
        dl[j] <= '0;
      end
      clr_pend <= 1'b0;
    end else if (pop) begin
      dl[0] <= q_x;
      for (int j = 1; j < NT; j++) begin
        dl[j] <= clr_pend ? '0 : dl[j-1];
      end
      clr_pend <= q_ctl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_last <= q_ctl.last;
      for (int j = 0; j < NT; j++) begin
        prod[j] <= PROD_W'(tap_eff[j] * dl[j]);
      end
      s1_last     <= s0_last;
      acc         <= sum;
      s2_last     <= s1_last;
      result      <= sat;
      result_last <= s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s0_valid  <= pop && q_ctl.emit;
      s1_valid  <= s0_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

endmodule

/* hw/rtl/same_mode_convolution_unit.sv */
// Data path: queue, delay line, product, sum, output register; one result per cycle if m_tready.
// Throughput: one sample per cycle while the queue has room; a sample marked last adds N flush
// shifts (N = half_width), zero samples the front issues into the queue while s_tready is low.
// The 4-entry queue between front and multiply pipeline absorbs output stalls.
// Reset (rst, synchronous): taps 0, half_width 1, delay line and counters cleared.
module same_mode_convolution_unit
  import smcu_pkg::*;
#(
  parameter int MAX_TAPS    = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                               s_tlast,   // is_last
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,   // [SAMPLE_BITS-1:0] result
  output logic                               m_tlast,   // result_last
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  logic signed [TAP_BITS-1:0]    taps [TAP_REGS];
  logic [HW_BITS-1:0]            half_width;
  logic [REG_IDX_BITS-1:0]       reg_idx;
  logic                          wr_en;
  logic                          push;
  logic signed [SAMPLE_BITS-1:0] push_x;
  op_ctl_t                       push_ctl;
  logic                          q_full;
  logic                          pop;
  logic                          q_valid;
  logic signed [SAMPLE_BITS-1:0] q_x;
  op_ctl_t                       q_ctl;
  logic signed [SAMPLE_BITS-1:0] result;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAP_REGS; i++) begin
        taps[i] <= '0;
      end
      half_width <= HALF_WIDTH_RST;
    end else if (wr_en) begin
      if (reg_idx == REG_HALF_WIDTH) begin
        half_width <= pwdata[HW_BITS-1:0];
      end else begin
        taps[reg_idx] <= pwdata[TAP_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx == REG_HALF_WIDTH) begin
      prdata = 32'(half_width);
    end else begin
      prdata = 32'($unsigned(taps[reg_idx]));
    end
  end

  smcu_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .sample    (s_tdata[SAMPLE_BITS-1:0]),
    .is_last   (s_tlast),
    .half_width(half_width),
    .q_full    (q_full),
    .push      (push),
    .push_x    (push_x),
    .push_ctl  (push_ctl)
  );

  smcu_queue #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .DEPTH      (4)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_x   (push_x),
    .push_ctl (push_ctl),
    .full     (q_full),
    .pop      (pop),
    .pop_valid(q_valid),
    .pop_x    (q_x),
    .pop_ctl  (q_ctl)
  );

  smcu_back #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_x        (q_x),
    .q_ctl      (q_ctl),
    .pop        (pop),
    .taps       (taps),
    .half_width (half_width),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .result     (result),
    .result_last(m_tlast)
  );

  assign m_tdata = TDATA_W'($unsigned(result));

endmodule
